[rtl/core/ibs_pkg.sv]
// Package for the indexed block store: operation and status codes, sequencer
// states and default sizes. No dependencies.
package ibs_pkg;
    localparam int DISK_BYTES_DEF = 256;
    localparam int MAX_FILES_DEF = 16;

    typedef enum logic [2:0] {
        OP_FORMAT = 3'd0, OP_CREATE = 3'd1, OP_OPEN = 3'd2, OP_CLOSE = 3'd3,
        OP_APPEND = 3'd4, OP_READ = 3'd5, OP_DELETE = 3'd6, OP_NONE = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_UNFORMATTED = 4'd1, ST_DISK_FULL = 4'd2,
        ST_INDEX_FULL = 4'd3, ST_NO_FILE = 4'd4, ST_NOT_OPEN = 4'd5,
        ST_ALREADY_OPEN = 4'd6, ST_BEYOND_END = 4'd7, ST_NO_SLOT = 4'd8
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_FMT_DIV, S_FMT_CLR, S_DISPATCH, S_CR_SCAN, S_ALLOC, S_AL_CHK,
        S_AL_DONE, S_AP_RDIX, S_AP_WAIT, S_AP_WDATA, S_AP_WIX, S_AP_WNEW,
        S_RD_DIV, S_RD_IX, S_RD_IXW, S_RD_DAT, S_RD_DATW, S_DL_RDIX,
        S_DL_RDW, S_DL_FREE, S_DL_CLR, S_DL_NEXT, S_DONE
    } t_state;
endpackage

[rtl/core/indexed_block_store_unit.sv]
// Indexed block store: one command per item. Format clears disk and bitmap; create and
// append scan the block bitmap one block at a time. The next item can be accepted as soon
// as the result shows, even while it waits. Reset is synchronous, active low, and leaves
// the store unformatted. Uses ibs_pkg, ibs_ram.
module indexed_block_store_unit #(
    parameter int DISK_BYTES = ibs_pkg::DISK_BYTES_DEF,
    parameter int MAX_FILES = ibs_pkg::MAX_FILES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_operation,
    input  logic [3:0] i_file_slot,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_byte_offset,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_status,
    output logic [7:0] o_read_byte,
    output logic [3:0] o_slot_given
);
    localparam int AW = $clog2(DISK_BYTES);
    localparam int NSLOT = (MAX_FILES < 16) ? MAX_FILES : 16;
    localparam int SW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int CNTW = 9;
    localparam int MAX_BLOCKS = 256;

    ibs_pkg::t_state r_state, n_state;

    logic [5:0] r_cfg;
    logic [5:0] r_bsize, n_bsize;
    logic [CNTW-1:0] r_nblocks, n_nblocks;
    logic [CNTW-1:0] r_free, n_free;
    logic r_fmt, n_fmt;
    logic [NSLOT-1:0] r_sval, n_sval, r_sopen, n_sopen;
    logic [8:0] r_slen [NSLOT];
    logic [5:0] r_sblk [NSLOT];
    logic [7:0] r_sidx [NSLOT];
    logic [8:0] n_slen;
    logic [5:0] n_sblk;
    logic [7:0] n_sidx;
    logic n_swr;

    logic [2:0] r_op, n_op;
    logic [3:0] r_slot, n_slot;
    logic [7:0] r_data, n_data, r_off, n_off;
    logic [3:0] r_status, n_status, r_given, n_given;
    logic [7:0] r_rbyte, n_rbyte;
    logic r_ovalid, n_ovalid;
    logic [3:0] r_ostatus, n_ostatus, r_ogiven, n_ogiven;
    logic [7:0] r_orbyte, n_orbyte;

    logic [12:0] r_acc, n_acc;
    logic [8:0] r_cnt, n_cnt;
    logic [8:0] r_quo, n_quo;
    logic [5:0] r_j, n_j;
    logic [7:0] r_blk, n_blk;
    logic [12:0] r_base, n_base;
    logic [5:0] r_frag, n_frag;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0] ram_wdata, ram_rdata;
    logic [12:0] addr_full;

    logic tkn_we;
    logic [7:0] tkn_addr;
    logic tkn_wdata, tkn_rdata;

    logic [SW-1:0] sidx;
    assign sidx = r_slot[SW-1:0];
    logic slot_ok;
    assign slot_ok = ({1'b0, r_slot} < 5'(NSLOT)) && r_sval[sidx];

    ibs_ram #(.WIDTH(8), .DEPTH(DISK_BYTES)) u_disk (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    ibs_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_taken (
        .i_clk(i_clk), .i_we(tkn_we), .i_addr(tkn_addr),
        .i_wdata(tkn_wdata), .o_rdata(tkn_rdata)
    );

    assign o_ready = (r_state == ibs_pkg::S_IDLE);
    assign o_valid = r_ovalid;
    assign o_status = r_ostatus;
    assign o_read_byte = r_orbyte;
    assign o_slot_given = r_ogiven;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibs_pkg::S_IDLE;
            r_cfg <= 6'd4;
            r_bsize <= 6'd4;
            r_nblocks <= '0;
            r_free <= '0;
            r_fmt <= 1'b0;
            r_sval <= '0;
            r_sopen <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NSLOT; k++) begin
                r_slen[k] <= '0;
                r_sblk[k] <= '0;
                r_sidx[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_bsize <= n_bsize;
            r_nblocks <= n_nblocks;
            r_free <= n_free;
            r_fmt <= n_fmt;
            r_sval <= n_sval;
            r_sopen <= n_sopen;
            r_ovalid <= n_ovalid;
            if (n_swr) begin
                r_slen[sidx] <= n_slen;
                r_sblk[sidx] <= n_sblk;
                r_sidx[sidx] <= n_sidx;
            end
        end
        r_op <= n_op; r_slot <= n_slot; r_data <= n_data; r_off <= n_off;
        r_status <= n_status; r_given <= n_given; r_rbyte <= n_rbyte;
        r_ostatus <= n_ostatus; r_ogiven <= n_ogiven; r_orbyte <= n_orbyte;
        r_acc <= n_acc; r_cnt <= n_cnt; r_quo <= n_quo; r_j <= n_j;
        r_blk <= n_blk; r_base <= n_base; r_frag <= n_frag;
    end

    always_comb begin
        n_state = r_state;
        n_bsize = r_bsize; n_nblocks = r_nblocks; n_free = r_free; n_fmt = r_fmt;
        n_sval = r_sval; n_sopen = r_sopen;
        n_swr = 1'b0;
        n_slen = r_slen[sidx]; n_sblk = r_sblk[sidx]; n_sidx = r_sidx[sidx];
        n_op = r_op; n_slot = r_slot; n_data = r_data; n_off = r_off;
        n_status = r_status; n_given = r_given; n_rbyte = r_rbyte;
        n_ovalid = r_ovalid;
        n_ostatus = r_ostatus; n_ogiven = r_ogiven; n_orbyte = r_orbyte;
        n_acc = r_acc; n_cnt = r_cnt; n_quo = r_quo; n_j = r_j;
        n_blk = r_blk; n_base = r_base; n_frag = r_frag;
        ram_we = 1'b0; ram_wdata = 8'd0; addr_full = r_acc;
        tkn_we = 1'b0; tkn_wdata = 1'b0; tkn_addr = r_cnt[7:0];
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ibs_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_op = i_operation; n_slot = i_file_slot;
                    n_data = i_data_byte; n_off = i_byte_offset;
                    n_status = ibs_pkg::ST_OK; n_rbyte = 8'd0; n_given = i_file_slot;
                    if (i_operation == ibs_pkg::OP_FORMAT) begin
                        n_bsize = (r_cfg == 6'd0) ? 6'd1 : ((r_cfg > 6'd32) ? 6'd32 : r_cfg);
                        n_acc = 13'(DISK_BYTES);
                        n_quo = '0;
                        n_state = ibs_pkg::S_FMT_DIV;
                    end else if (i_operation == ibs_pkg::OP_NONE) begin
                        n_state = ibs_pkg::S_DONE;
                    end else if (!r_fmt) begin
                        n_status = ibs_pkg::ST_UNFORMATTED;
                        n_state = ibs_pkg::S_DONE;
                    end else begin
                        n_state = ibs_pkg::S_DISPATCH;
                    end
                end
            end
            ibs_pkg::S_FMT_DIV: begin
                if (r_acc >= 13'(r_bsize) && r_quo < 9'd256) begin
                    n_acc = r_acc - 13'(r_bsize);
                    n_quo = r_quo + 9'd1;
                end else begin
                    n_nblocks = (r_quo > 9'd256) ? 9'd256 : r_quo;
                    n_free = n_nblocks;
                    n_fmt = 1'b1;
                    n_sval = '0; n_sopen = '0;
                    n_acc = '0;
                    n_state = ibs_pkg::S_FMT_CLR;
                end
            end
            ibs_pkg::S_FMT_CLR: begin
                ram_we = 1'b1;
                addr_full = r_acc;
                tkn_we = (r_acc < 13'(MAX_BLOCKS));
                tkn_addr = r_acc[7:0];
                if (r_acc == 13'(DISK_BYTES - 1)) begin
                    n_state = ibs_pkg::S_DONE;
                end
                n_acc = r_acc + 13'd1;
            end
            ibs_pkg::S_DISPATCH: begin
                if (r_op == ibs_pkg::OP_CREATE) begin
                    if (r_free == '0) begin
                        n_status = ibs_pkg::ST_DISK_FULL;
                        n_state = ibs_pkg::S_DONE;
                    end else begin
                        n_slot = 4'd0;
                        n_state = ibs_pkg::S_CR_SCAN;
                    end
                end else if (!slot_ok) begin
                    n_status = ibs_pkg::ST_NO_FILE;
                    n_state = ibs_pkg::S_DONE;
                end else begin
                    case (r_op)
                        ibs_pkg::OP_OPEN: begin
                            if (r_sopen[sidx]) n_status = ibs_pkg::ST_ALREADY_OPEN;
                            else n_sopen[sidx] = 1'b1;
                            n_state = ibs_pkg::S_DONE;
                        end
                        ibs_pkg::OP_CLOSE: begin
                            if (!r_sopen[sidx]) n_status = ibs_pkg::ST_NOT_OPEN;
                            else n_sopen[sidx] = 1'b0;
                            n_state = ibs_pkg::S_DONE;
                        end
                        ibs_pkg::OP_APPEND, ibs_pkg::OP_READ: begin
                            if (!r_sopen[sidx]) begin
                                n_status = ibs_pkg::ST_NOT_OPEN;
                                n_state = ibs_pkg::S_DONE;
                            end else if (r_op == ibs_pkg::OP_READ &&
                                         {1'b0, r_off} >= r_slen[sidx]) begin
                                n_status = ibs_pkg::ST_BEYOND_END;
                                n_state = ibs_pkg::S_DONE;
                            end else begin
                                n_acc = (r_op == ibs_pkg::OP_READ) ? 13'(r_off)
                                                                   : 13'(r_slen[sidx]);
                                n_quo = '0;
                                n_state = ibs_pkg::S_RD_DIV;
                            end
                        end
                        default: begin
                            n_j = '0;
                            n_state = ibs_pkg::S_DL_RDIX;
                        end
                    endcase
                end
            end
            ibs_pkg::S_CR_SCAN: begin
                if (!r_sval[sidx]) begin
                    n_cnt = '0;
                    n_state = ibs_pkg::S_ALLOC;
                end else if ({1'b0, r_slot} >= 5'(NSLOT - 1)) begin
                    n_status = ibs_pkg::ST_NO_SLOT;
                    n_slot = r_given;
                    n_state = ibs_pkg::S_DONE;
                end else begin
                    n_slot = r_slot + 4'd1;
                end
            end
            ibs_pkg::S_ALLOC: begin
                tkn_addr = r_cnt[7:0];
                if (r_cnt >= r_nblocks || r_cnt[8]) begin
                    n_blk = 8'd0;
                    n_state = ibs_pkg::S_AL_DONE;
                end else begin
                    n_state = ibs_pkg::S_AL_CHK;
                end
            end
            ibs_pkg::S_AL_CHK: begin
                tkn_addr = r_cnt[7:0];
                if (!tkn_rdata) begin
                    tkn_we = 1'b1; tkn_wdata = 1'b1;
                    if (r_free != '0) n_free = r_free - 9'd1;
                    n_blk = r_cnt[7:0];
                    n_state = ibs_pkg::S_AL_DONE;
                end else begin
                    n_cnt = r_cnt + 9'd1;
                    n_state = ibs_pkg::S_ALLOC;
                end
            end
            ibs_pkg::S_AL_DONE: begin
                if (r_op == ibs_pkg::OP_CREATE) begin
                    n_sval[sidx] = 1'b1; n_sopen[sidx] = 1'b1;
                    n_swr = 1'b1; n_slen = '0; n_sblk = '0; n_sidx = r_blk;
                    n_given = r_slot;
                    n_state = ibs_pkg::S_DONE;
                end else begin
                    n_state = ibs_pkg::S_AP_WIX;
                end
            end
            ibs_pkg::S_RD_DIV: begin
                if (r_acc >= 13'(r_bsize)) begin
                    n_acc = r_acc - 13'(r_bsize);
                    n_quo = r_quo + 9'd1;
                end else begin
                    n_frag = r_acc[5:0];
                    n_base = 13'(r_sidx[sidx]) * 13'(r_bsize);
                    n_state = (r_op == ibs_pkg::OP_READ) ? ibs_pkg::S_RD_IX
                                                         : ibs_pkg::S_AP_RDIX;
                end
            end
            ibs_pkg::S_AP_RDIX: begin
                if (r_frag != '0 && r_sblk[sidx] != '0) begin
                    addr_full = r_base + 13'(r_sblk[sidx]) - 13'd1;
                    n_state = ibs_pkg::S_AP_WAIT;
                end else if (r_sblk[sidx] >= r_bsize) begin
                    n_status = ibs_pkg::ST_INDEX_FULL;
                    n_state = ibs_pkg::S_DONE;
                end else if (r_free == '0) begin
                    n_status = ibs_pkg::ST_DISK_FULL;
                    n_state = ibs_pkg::S_DONE;
                end else begin
                    n_cnt = '0;
                    n_state = ibs_pkg::S_ALLOC;
                end
            end
            ibs_pkg::S_AP_WAIT: begin
                n_base = 13'(ram_rdata) * 13'(r_bsize);
                n_state = ibs_pkg::S_AP_WDATA;
            end
            ibs_pkg::S_AP_WDATA: begin
                addr_full = r_base + 13'(r_frag);
                ram_we = 1'b1; ram_wdata = r_data;
                n_swr = 1'b1; n_slen = r_slen[sidx] + 9'd1;
                n_state = ibs_pkg::S_DONE;
            end
            ibs_pkg::S_AP_WIX: begin
                addr_full = r_base + 13'(r_sblk[sidx]);
                ram_we = 1'b1; ram_wdata = r_blk;
                n_swr = 1'b1; n_sblk = r_sblk[sidx] + 6'd1;
                n_base = 13'(r_blk) * 13'(r_bsize);
                n_state = ibs_pkg::S_AP_WNEW;
            end
            ibs_pkg::S_AP_WNEW: begin
                addr_full = r_base;
                ram_we = 1'b1; ram_wdata = r_data;
                n_swr = 1'b1; n_slen = r_slen[sidx] + 9'd1;
                n_state = ibs_pkg::S_DONE;
            end
            ibs_pkg::S_RD_IX: begin
                addr_full = r_base + 13'(r_quo);
                n_state = ibs_pkg::S_RD_IXW;
            end
            ibs_pkg::S_RD_IXW: begin
                n_base = 13'(ram_rdata) * 13'(r_bsize);
                n_state = ibs_pkg::S_RD_DAT;
            end
            ibs_pkg::S_RD_DAT: begin
                addr_full = r_base + 13'(r_frag);
                n_state = ibs_pkg::S_RD_DATW;
            end
            ibs_pkg::S_RD_DATW: begin
                n_rbyte = ram_rdata;
                n_state = ibs_pkg::S_DONE;
            end
            ibs_pkg::S_DL_RDIX: begin
                if (r_j < r_sblk[sidx] && r_j < r_bsize) begin
                    addr_full = 13'(r_sidx[sidx]) * 13'(r_bsize) + 13'(r_j);
                    n_state = ibs_pkg::S_DL_RDW;
                end else begin
                    n_blk = r_sidx[sidx];
                    n_j = r_bsize;
                    n_state = ibs_pkg::S_DL_FREE;
                end
            end
            ibs_pkg::S_DL_RDW: begin
                n_blk = ram_rdata;
                n_state = ibs_pkg::S_DL_FREE;
            end
            ibs_pkg::S_DL_FREE: begin
                tkn_addr = r_blk;
                n_base = 13'(r_blk) * 13'(r_bsize);
                n_cnt = '0;
                n_state = ibs_pkg::S_DL_CLR;
            end
            ibs_pkg::S_DL_CLR: begin
                tkn_addr = r_blk;
                if (r_cnt == '0 && tkn_rdata) begin
                    tkn_we = 1'b1;
                    n_free = r_free + 9'd1;
                end
                addr_full = r_base + 13'(r_cnt);
                ram_we = 1'b1;
                n_cnt = r_cnt + 9'd1;
                if (r_cnt + 9'd1 >= 9'(r_bsize)) n_state = ibs_pkg::S_DL_NEXT;
            end
            ibs_pkg::S_DL_NEXT: begin
                if (r_j >= r_bsize) begin
                    n_sval[sidx] = 1'b0; n_sopen[sidx] = 1'b0;
                    n_swr = 1'b1; n_slen = '0; n_sblk = '0; n_sidx = '0;
                    n_state = ibs_pkg::S_DONE;
                end else begin
                    n_j = r_j + 6'd1;
                    n_state = ibs_pkg::S_DL_RDIX;
                end
            end
            ibs_pkg::S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ostatus = r_status; n_orbyte = r_rbyte; n_ogiven = r_given;
                    n_state = ibs_pkg::S_IDLE;
                end
            end
            default: n_state = ibs_pkg::S_IDLE;
        endcase
        if (addr_full >= 13'(DISK_BYTES)) ram_we = 1'b0;
        ram_addr = addr_full[AW-1:0];
    end
endmodule

[rtl/core/ibs_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module ibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/core/ibs_checker.sv]
// Port-level checks for the indexed block store; bound to the top level.
// Depends on ibs_pkg for status codes.
module ibs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [3:0] o_status,
    input logic [7:0] o_read_byte
);
    a_byte_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_read_byte)) else $error("byte changed");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("ready right after accept");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ibs_pkg::ST_NO_SLOT)) else $error("bad status");
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ibs_pkg::ST_OK) |-> (o_read_byte == 8'd0))
        else $error("byte on error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("result dropped");
endmodule

bind indexed_block_store_unit ibs_checker u_ibs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_read_byte(o_read_byte)
);

[dv/testbench.sv]
// Testbench for indexed_block_store_unit: drives file store commands through the
// valid/ready channels and checks every result against a behavioral store model.
// Depends on ibs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    typedef struct packed {
        logic [3:0] status;
        logic [7:0] rbyte;
        logic [3:0] given;
    } t_answer;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [5:0] i_cfg_wdata = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [2:0] i_operation = '0;
    logic [3:0] i_file_slot = '0;
    logic [7:0] i_data_byte = '0;
    logic [7:0] i_byte_offset = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [3:0] o_status;
    logic [7:0] o_read_byte;
    logic [3:0] o_slot_given;

    indexed_block_store_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_file_slot(i_file_slot),
        .i_data_byte(i_data_byte), .i_byte_offset(i_byte_offset),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_read_byte(o_read_byte), .o_slot_given(o_slot_given)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [7:0]  disk_mem [256];
    logic        blk_used [256];
    int unsigned free_blocks;
    logic        is_formatted;
    logic        f_valid [16];
    logic        f_open [16];
    int unsigned f_len [16];
    int unsigned f_nblk [16];
    int unsigned f_ix [16];
    int unsigned cfg_size;
    int unsigned blk_size;
    int unsigned blk_total;

    t_answer answers_due[$];
    int      fail_count = 0;
    bit      quiet = 1'b0;

    function automatic logic [7:0] dget(int unsigned a);
        return a < 256 ? disk_mem[a] : 8'd0;
    endfunction

    function automatic void dput(int unsigned a, logic [7:0] v);
        if (a < 256) disk_mem[a] = v;
    endfunction

    function automatic int unsigned grab_block();
        for (int unsigned i = 0; i < blk_total && i < 256; i++) begin
            if (!blk_used[i]) begin
                blk_used[i] = 1'b1;
                if (free_blocks > 0) free_blocks--;
                return i;
            end
        end
        return 0;
    endfunction

    function automatic void release_block(int unsigned b);
        if (b < 256 && blk_used[b]) begin
            blk_used[b] = 1'b0;
            free_blocks++;
        end
        for (int unsigned i = 0; i < blk_size; i++) dput(b * blk_size + i, 8'd0);
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < 256; i++) begin
            disk_mem[i] = 8'd0;
            blk_used[i] = 1'b0;
        end
        for (int i = 0; i < 16; i++) begin
            f_valid[i] = 1'b0; f_open[i] = 1'b0;
            f_len[i] = 0; f_nblk[i] = 0; f_ix[i] = 0;
        end
    endfunction

    function automatic t_answer store_command(ibs_pkg::t_op op, logic [3:0] slot,
                                              logic [7:0] data, logic [7:0] off);
        t_answer r;
        int unsigned s, frag, ib, db, nb;
        r.status = ibs_pkg::ST_OK;
        r.rbyte = 8'd0;
        r.given = slot;
        if (op == ibs_pkg::OP_FORMAT) begin
            blk_size = cfg_size == 0 ? 1 : (cfg_size > 32 ? 32 : cfg_size);
            blk_total = 256 / blk_size;
            wipe_store();
            free_blocks = blk_total;
            is_formatted = 1'b1;
        end else if (op == ibs_pkg::OP_NONE) begin
        end else if (!is_formatted) begin
            r.status = ibs_pkg::ST_UNFORMATTED;
        end else if (op == ibs_pkg::OP_CREATE) begin
            s = 16;
            for (int unsigned i = 0; i < 16; i++)
                if (!f_valid[i] && s == 16) s = i;
            if (free_blocks == 0) r.status = ibs_pkg::ST_DISK_FULL;
            else if (s >= 16) r.status = ibs_pkg::ST_NO_SLOT;
            else begin
                f_valid[s] = 1'b1; f_open[s] = 1'b1;
                f_len[s] = 0; f_nblk[s] = 0;
                f_ix[s] = grab_block();
                r.given = s[3:0];
            end
        end else if (!f_valid[slot]) begin
            r.status = ibs_pkg::ST_NO_FILE;
        end else if (op == ibs_pkg::OP_OPEN) begin
            if (f_open[slot]) r.status = ibs_pkg::ST_ALREADY_OPEN;
            else f_open[slot] = 1'b1;
        end else if (op == ibs_pkg::OP_CLOSE) begin
            if (!f_open[slot]) r.status = ibs_pkg::ST_NOT_OPEN;
            else f_open[slot] = 1'b0;
        end else if (op == ibs_pkg::OP_APPEND) begin
            frag = f_len[slot] % blk_size;
            ib = f_ix[slot];
            if (!f_open[slot]) r.status = ibs_pkg::ST_NOT_OPEN;
            else if (frag != 0 && f_nblk[slot] > 0) begin
                db = dget(ib * blk_size + f_nblk[slot] - 1);
                dput(db * blk_size + frag, data);
                f_len[slot] = (f_len[slot] + 1) & 9'h1FF;
            end else if (f_nblk[slot] >= blk_size) r.status = ibs_pkg::ST_INDEX_FULL;
            else if (free_blocks == 0) r.status = ibs_pkg::ST_DISK_FULL;
            else begin
                nb = grab_block();
                dput(ib * blk_size + f_nblk[slot], nb[7:0]);
                f_nblk[slot]++;
                dput(nb * blk_size, data);
                f_len[slot] = (f_len[slot] + 1) & 9'h1FF;
            end
        end else if (op == ibs_pkg::OP_READ) begin
            if (!f_open[slot]) r.status = ibs_pkg::ST_NOT_OPEN;
            else if (off >= f_len[slot]) r.status = ibs_pkg::ST_BEYOND_END;
            else begin
                db = dget(f_ix[slot] * blk_size + off / blk_size);
                r.rbyte = dget(db * blk_size + off % blk_size);
            end
        end else begin
            ib = f_ix[slot];
            for (int unsigned i = 0; i < f_nblk[slot] && i < blk_size; i++)
                release_block(dget(ib * blk_size + i));
            release_block(ib);
            f_valid[slot] = 1'b0; f_open[slot] = 1'b0;
            f_len[slot] = 0; f_nblk[slot] = 0; f_ix[slot] = 0;
        end
        return r;
    endfunction

    task automatic send_item(ibs_pkg::t_op op, logic [3:0] slot, logic [7:0] data,
                             logic [7:0] off);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        answers_due = {answers_due, store_command(op, slot, data, off)};
        i_valid <= 1'b1;
        i_operation <= op;
        i_file_slot <= slot;
        i_data_byte <= data;
        i_byte_offset <= off;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_block_size(logic [5:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_size = v;
    endtask

    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, o_status);
                fail_count++;
            end else begin
                t_answer e;
                e = answers_due.pop_front();
                if (o_status !== e.status || o_read_byte !== e.rbyte ||
                    o_slot_given !== e.given) begin
                    $display("%0t: expected st=%0d rd=%0h sl=%0d, got st=%0d rd=%0h sl=%0d",
                             $time, e.status, e.rbyte, e.given,
                             o_status, o_read_byte, o_slot_given);
                    fail_count++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 9) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_item(ibs_pkg::OP_CREATE, 4'd0, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_READ, 4'd0, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_NONE, 4'd15, 8'hFF, 8'hFF);
        send_item(ibs_pkg::OP_FORMAT, 4'd0, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_CREATE, 4'd9, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_OPEN, 4'd0, 8'd0, 8'd0);
        for (int i = 0; i < 6; i++)
            send_item(ibs_pkg::OP_APPEND, 4'd0, i == 0 ? 8'hFF : 8'(i * 37), 8'd0);
        send_item(ibs_pkg::OP_READ, 4'd0, 8'd0, 8'd5);
        send_item(ibs_pkg::OP_READ, 4'd0, 8'd0, 8'd6);
        send_item(ibs_pkg::OP_READ, 4'd0, 8'd0, 8'hFF);
        send_item(ibs_pkg::OP_CLOSE, 4'd0, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_CLOSE, 4'd0, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_APPEND, 4'd0, 8'd1, 8'd0);
        send_item(ibs_pkg::OP_READ, 4'd0, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_OPEN, 4'd15, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_DELETE, 4'd0, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_DELETE, 4'd0, 8'd0, 8'd0);
        send_item(ibs_pkg::OP_NONE, 4'd0, 8'd0, 8'd0);
    endtask

    task automatic test_size_extremes();
        logic [5:0] sizes [5] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2};
        foreach (sizes[k]) begin
            set_block_size(sizes[k]);
            send_item(ibs_pkg::OP_FORMAT, 4'($urandom), 8'd0, 8'd0);
            for (int i = 0; i < 18; i++) send_item(ibs_pkg::OP_CREATE, 4'd0, 8'd0, 8'd0);
            for (int i = 0; i < 40; i++)
                send_item(ibs_pkg::OP_APPEND, 4'($urandom_range(0, 2)), 8'($urandom),
                          8'd0);
            for (int i = 0; i < 6; i++)
                send_item(ibs_pkg::OP_READ, 4'($urandom_range(0, 2)), 8'd0,
                          8'($urandom_range(0, 20)));
        end
    endtask

    task automatic test_random_mix(int n, bit is_last);
        ibs_pkg::t_op op;
        logic [3:0] slot;
        for (int i = 0; i < n; i++) begin
            if (is_last && i == n / 2) quiet = 1'b1;
            if (i % 150 == 75) begin
                set_block_size(6'($urandom_range(1, 12)));
                send_item(ibs_pkg::OP_FORMAT, 4'd0, 8'd0, 8'd0);
            end
            case ($urandom_range(0, 19))
                0, 1, 2:  op = ibs_pkg::OP_CREATE;
                3:        op = ibs_pkg::OP_OPEN;
                4:        op = ibs_pkg::OP_CLOSE;
                5, 6:     op = ibs_pkg::OP_DELETE;
                7:        op = ibs_pkg::t_op'($urandom_range(0, 7));
                8, 9, 10, 11: op = ibs_pkg::OP_READ;
                default:  op = ibs_pkg::OP_APPEND;
            endcase
            slot = $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 4));
            send_item(op, slot, 8'($urandom), $urandom_range(0, 1) ?
                      8'($urandom_range(0, 40)) : 8'($urandom));
        end
    endtask

    initial begin
        cfg_size = 4;
        blk_size = 4;
        blk_total = 0;
        free_blocks = 0;
        is_formatted = 1'b0;
        wipe_store();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_size_extremes();
        drain_results();
        test_random_mix(550, 1'b1);
        drain_results();
        if (fail_count == 0)
            $display("indexed_block_store_unit: match");
        else
            $display("indexed_block_store_unit: mismatch");
        $finish;
    end

    initial begin
        #50000000;
        $display("indexed_block_store_unit: mismatch");
        $finish;
    end
endmodule
